// ===== hw/rtl/s7e8_pkg.sv =====
// Shared types and constants for the seven-in-eight byte encoder.
// Used by every module of the encoder core; depends on nothing else.
package s7e8_pkg;

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_END  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_of_run;
  } out_item_t;

  // Results of one request, handed from the packer to the output buffer.
  typedef struct packed {
    logic [1:0] n_results;
    out_item_t  res0;
    out_item_t  res1;
  } step_res_t;

  localparam logic [7:0] CONT_BIT  = 8'h80;
  localparam logic [7:0] FULL_MASK = 8'hFF;
  localparam logic [7:0] LOW7_MASK = 8'h7F;
  localparam logic [7:0] ZERO_CODE = 8'h00;
  localparam logic [2:0] POS_LAST  = 3'd7;
  localparam logic [2:0] POS_MAX   = 3'd6;

endpackage

// ===== hw/rtl/s7e8_in_reg.sv =====
// Input register of the encoder core: holds one request until the packer takes it.
// Depends on s7e8_pkg for the request type.
module s7e8_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               data_valid,
  output logic               data_stall,
  input  s7e8_pkg::in_item_t data_item,
  input  logic               take,
  output logic               held_valid,
  output s7e8_pkg::in_item_t held_item
);

  always_comb begin
    data_stall = held_valid && !take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (data_valid && !data_stall) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && !data_stall) begin
      held_item <= data_item;
    end
  end

endmodule

// ===== hw/rtl/s7e8_pack.sv =====
// Packer of the encoder core: the 7-bit window state and the logic that turns
// one request into zero, one or two code bytes. Depends on s7e8_pkg.
module s7e8_pack (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  s7e8_pkg::in_item_t  item,
  output s7e8_pkg::step_res_t step
);

  logic       empty_flag;
  logic [2:0] bit_position;
  logic [6:0] carry_bits;
  logic [7:0] pending_byte;

  logic       empty_flag_next;
  logic [2:0] bit_position_next;
  logic [6:0] carry_bits_next;
  logic [7:0] pending_byte_next;

  logic [2:0] pos_d;
  logic [7:0] mask_d;
  logic [2:0] pos_e;
  logic [7:0] mask_e;
  logic [7:0] low_e;
  logic [7:0] carry_w;

  always_comb begin
    pos_d   = (bit_position == s7e8_pkg::POS_LAST) ? s7e8_pkg::POS_LAST : bit_position + 3'd1;
    mask_d  = s7e8_pkg::FULL_MASK >> pos_d;
    pos_e   = (bit_position > s7e8_pkg::POS_MAX) ? s7e8_pkg::POS_MAX : bit_position;
    mask_e  = s7e8_pkg::LOW7_MASK >> pos_e;
    low_e   = pending_byte & mask_e;
    carry_w = {1'b0, carry_bits};

    empty_flag_next   = empty_flag;
    bit_position_next = bit_position;
    carry_bits_next   = carry_bits;
    pending_byte_next = pending_byte;

    step                  = '0;
    step.res0.code_byte   = s7e8_pkg::ZERO_CODE;
    step.res1.code_byte   = s7e8_pkg::ZERO_CODE;

    if (item.command == s7e8_pkg::CMD_DATA) begin
      pending_byte_next = item.data_byte;
      empty_flag_next   = 1'b0;
      if (empty_flag) begin
        carry_bits_next   = '0;
        bit_position_next = '0;
      end else begin
        step.res0.code_byte = s7e8_pkg::CONT_BIT | carry_w | (pending_byte & mask_d);
        if (pos_d == s7e8_pkg::POS_LAST) begin
          // The window wrapped: the upper seven bits go out as a byte of their own.
          step.n_results        = 2'd2;
          step.res1.code_byte   = s7e8_pkg::CONT_BIT | {1'b0, pending_byte[7:1]};
          step.res1.last_of_run = 1'b1;
          carry_bits_next       = '0;
          bit_position_next     = '0;
        end else begin
          step.n_results        = 2'd1;
          step.res0.last_of_run = 1'b1;
          carry_bits_next       = 7'((pending_byte & ~mask_d) >> 1);
          bit_position_next     = pos_d;
        end
      end
    end else begin
      empty_flag_next   = 1'b1;
      bit_position_next = '0;
      carry_bits_next   = '0;
      pending_byte_next = '0;
      if (empty_flag) begin
        step.n_results        = 2'd1;
        step.res0.code_byte   = s7e8_pkg::ZERO_CODE;
        step.res0.last_of_run = 1'b1;
      end else if (bit_position == 3'd0) begin
        if (!pending_byte[7] && pending_byte != 8'd0) begin
          step.n_results        = 2'd1;
          step.res0.code_byte   = pending_byte;
          step.res0.last_of_run = 1'b1;
        end else begin
          step.n_results        = 2'd2;
          step.res0.code_byte   = s7e8_pkg::CONT_BIT | (pending_byte & s7e8_pkg::LOW7_MASK);
          step.res1.code_byte   = {1'b0, pending_byte[7], 6'd0};
          step.res1.last_of_run = 1'b1;
        end
      end else if (low_e != 8'd0 && low_e == pending_byte) begin
        step.n_results        = 2'd1;
        step.res0.code_byte   = carry_w | low_e;
        step.res0.last_of_run = 1'b1;
      end else begin
        step.n_results        = 2'd2;
        step.res0.code_byte   = s7e8_pkg::CONT_BIT | carry_w | low_e;
        step.res1.code_byte   = (pending_byte & ~mask_e) >> 1;
        step.res1.last_of_run = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_flag   <= 1'b1;
      bit_position <= '0;
      carry_bits   <= '0;
      pending_byte <= '0;
    end else if (fire) begin
      empty_flag   <= empty_flag_next;
      bit_position <= bit_position_next;
      carry_bits   <= carry_bits_next;
      pending_byte <= pending_byte_next;
    end
  end

endmodule

// ===== hw/rtl/s7e8_out_buf.sv =====
// Two-entry output buffer of the encoder core: takes all code bytes of one
// request at once and hands them out one per cycle while the output is not stalled. Depends on s7e8_pkg.
module s7e8_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  s7e8_pkg::step_res_t step,
  output logic                room,
  output logic                code_valid,
  input  logic                code_stall,
  output s7e8_pkg::out_item_t code_item
);

  logic [1:0]          count;
  s7e8_pkg::out_item_t slot0;
  s7e8_pkg::out_item_t slot1;
  logic                pop;

  always_comb begin
    code_valid = count != 2'd0;
    code_item  = slot0;
    pop        = code_valid && !code_stall;
    // A new request may land once the buffer drains in this cycle.
    room       = (count == 2'd0) || (count == 2'd1 && pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= step.n_results;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= step.res0;
      slot1 <= step.res1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

// ===== hw/rtl/seven_in_eight_byte_encoder_core.sv =====
// Top level of the seven-in-eight byte encoder core.
// Instantiates s7e8_in_reg, s7e8_pack and s7e8_out_buf; depends on s7e8_pkg.

// A request carries a data byte or an end command. Each data byte is held back
// until the next request arrives, and its bits leave as 7-bit code bytes with bit 7
// set while more follow; every seven data bytes give eight code bytes, and an end
// gives one or two bytes (a lone 0x00 for an empty string) before the encoder returns
// to the empty state. Requests that give no byte or one byte stream at one per cycle
// while the output does not stall; a request that gives two bytes (every seventh
// data byte and most ends) holds the input while the single byte-wide output port
// drains the two-entry output buffer. The first code byte is offered on the output
// once its request has passed the input register and been loaded into the buffer.
module seven_in_eight_byte_encoder_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                data_valid,
  output logic                data_stall,
  input  s7e8_pkg::in_item_t  data_item,
  output logic                code_valid,
  input  logic                code_stall,
  output s7e8_pkg::out_item_t code_item
);

  logic                held_valid;
  s7e8_pkg::in_item_t  held_item;
  s7e8_pkg::step_res_t step;
  logic                room;
  logic                fire;

  assign fire = held_valid && room;

  s7e8_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_item  (data_item),
    .take       (fire),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  s7e8_pack u_pack (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (held_item),
    .step (step)
  );

  s7e8_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .step       (step),
    .room       (room),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code_item  (code_item)
  );

`ifndef SYNTH
  // The first byte of a pair is never the last one, and its partner is.
  a_pair_marks: assert property (@(posedge clk) disable iff (rst)
    fire && step.n_results == 2'd2 |-> !step.res0.last_of_run && step.res1.last_of_run)
    else $error("two-byte request with wrong last_of_run marks");

  // A byte that is not last of its run is always followed by its partner.
  a_partner_follows: assert property (@(posedge clk) disable iff (rst)
    code_valid && !code_stall && !code_item.last_of_run |=> code_valid)
    else $error("continuation byte not followed by its partner");

  // A request that gives no byte leaves the output empty.
  a_silent_request: assert property (@(posedge clk) disable iff (rst)
    fire && step.n_results == 2'd0 |=> !code_valid)
    else $error("output valid after a request that gave no byte");
`endif

endmodule

// ===== sim/tb_seven_in_eight_byte_encoder_core.sv =====
// Testbench for seven_in_eight_byte_encoder_core: a directed table, then random strings,
// each code byte checked against the table's bytes where a row types them, else against
// a bit-true encoder model kept in this file. Depends on s7e8_pkg and the encoder RTL.
`timescale 1ns / 1ps

module tb_seven_in_eight_byte_encoder_core;

  localparam int ITEMS      = 1250;
  localparam int CALM_ITEMS = 150;
  localparam int QUIET_MAX  = 1000;
  localparam int PRED       = -1;
  localparam int DRAIN_STEP = 300;

  typedef struct {
    s7e8_pkg::in_item_t req;
    int                 n;
    logic [7:0]         c0;
    logic [7:0]         c1;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                data_valid = 1'b0;
  logic                data_stall;
  s7e8_pkg::in_item_t  data_item = '0;
  logic                code_valid;
  logic                code_stall = 1'b0;
  s7e8_pkg::out_item_t code_item;

  // Encoder model state.
  logic       held_empty = 1'b1;
  logic [2:0] win_pos = '0;
  logic [6:0] carry = '0;
  logic [7:0] held_byte = '0;

  s7e8_pkg::out_item_t code_q[$];
  dir_row_t            dir_rows[$];
  int                  mismatches = 0;
  int                  items_sent = 0;
  int                  quiet_cycles = 0;
  int                  stall_left = 0;
  int                  gap_odds = 5;
  logic                calm = 1'b0;

  seven_in_eight_byte_encoder_core dut (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_item  (data_item),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code_item  (code_item)
  );

  always #5 clk = ~clk;

  function automatic void encode_step(input s7e8_pkg::in_item_t it,
                                      output s7e8_pkg::out_item_t r0,
                                      output s7e8_pkg::out_item_t r1, output int n);
    logic [3:0] p;
    logic [7:0] mask;
    logic [7:0] low;
    logic [7:0] tmp;
    r0 = '0;
    r1 = '0;
    n  = 0;
    if (it.command == s7e8_pkg::CMD_DATA) begin
      if (held_empty) begin
        held_empty = 1'b0;
        carry      = '0;
        win_pos    = '0;
        held_byte  = it.data_byte;
      end else begin
        p    = {1'b0, win_pos} + 4'd1;
        mask = s7e8_pkg::FULL_MASK >> p;
        r0.code_byte   = s7e8_pkg::CONT_BIT | {1'b0, carry} | (held_byte & mask);
        r0.last_of_run = 1'b0;
        if (p == {1'b0, s7e8_pkg::POS_LAST}) begin
          // The window wrapped: the held byte's upper seven bits go out whole.
          r1.code_byte   = s7e8_pkg::CONT_BIT | (held_byte >> 1);
          r1.last_of_run = 1'b1;
          n       = 2;
          carry   = '0;
          win_pos = '0;
        end else begin
          r0.last_of_run = 1'b1;
          n       = 1;
          tmp     = (held_byte & ~mask) >> 1;
          carry   = tmp[6:0];
          win_pos = p[2:0];
        end
        held_byte = it.data_byte;
      end
    end else begin
      if (held_empty) begin
        r0.code_byte   = s7e8_pkg::ZERO_CODE;
        r0.last_of_run = 1'b1;
        n = 1;
      end else if (win_pos == 3'd0) begin
        if (held_byte[7] == 1'b0 && held_byte != s7e8_pkg::ZERO_CODE) begin
          r0.code_byte   = held_byte;
          r0.last_of_run = 1'b1;
          n = 1;
        end else begin
          r0.code_byte   = s7e8_pkg::CONT_BIT | (held_byte & s7e8_pkg::LOW7_MASK);
          r0.last_of_run = 1'b0;
          r1.code_byte   = (held_byte & s7e8_pkg::CONT_BIT) >> 1;
          r1.last_of_run = 1'b1;
          n = 2;
        end
      end else begin
        mask = s7e8_pkg::LOW7_MASK >> win_pos;
        low  = held_byte & mask;
        if (low != s7e8_pkg::ZERO_CODE && low == held_byte) begin
          r0.code_byte   = {1'b0, carry} | low;
          r0.last_of_run = 1'b1;
          n = 1;
        end else begin
          r0.code_byte   = s7e8_pkg::CONT_BIT | {1'b0, carry} | low;
          r0.last_of_run = 1'b0;
          r1.code_byte   = (held_byte & ~mask) >> 1;
          r1.last_of_run = 1'b1;
          n = 2;
        end
      end
      held_empty = 1'b1;
      win_pos    = '0;
      carry      = '0;
      held_byte  = '0;
    end
  endfunction

  task automatic add_row(input s7e8_pkg::cmd_t c, input logic [7:0] b, input int n,
                         input logic [7:0] c0, input logic [7:0] c1);
    dir_row_t r;
    r.req.command   = c;
    r.req.data_byte = b;
    r.n  = n;
    r.c0 = c0;
    r.c1 = c1;
    dir_rows.push_back(r);
  endtask

  // Offers one request, waits for it to be taken, then queues its code bytes.
  // A typed row count other than PRED replaces the model's bytes with the table's.
  task automatic send_req(input s7e8_pkg::in_item_t it, input int n_typed,
                          input logic [7:0] c0, input logic [7:0] c1);
    s7e8_pkg::out_item_t r0;
    s7e8_pkg::out_item_t r1;
    int                  n;
    if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      data_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    data_valid <= 1'b1;
    data_item  <= it;
    do @(posedge clk); while (data_stall);
    items_sent++;
    encode_step(it, r0, r1, n);
    if (n_typed != PRED) begin
      n = n_typed;
      r0.code_byte   = c0;
      r0.last_of_run = (n == 1);
      r1.code_byte   = c1;
      r1.last_of_run = 1'b1;
    end
    if (n >= 1) code_q.push_back(r0);
    if (n == 2) code_q.push_back(r1);
  endtask

  task automatic drain_all();
    data_valid <= 1'b0;
    do @(posedge clk); while (code_q.size() != 0);
  endtask

  // Leans on the corner values and on small bytes, which can end a string in a single code byte.
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: b = 8'h00;
          1: b = 8'h7F;
          2: b = 8'h80;
          default: b = 8'hFF;
        endcase
      end
      1, 2: b = 8'($urandom_range(1, 3));
      3: b = 8'($urandom_range(0, 63));
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // Receiver: random stall bursts, none once the run is calm.
  always @(posedge clk) begin
    if (rst || calm) begin
      code_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      code_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      code_stall <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      code_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    s7e8_pkg::out_item_t want;
    if (!rst && code_valid && !code_stall) begin
      if (code_q.size() == 0) begin
        $display("%0t: unexpected code byte, expected none, actual %h last %b",
                 $time, code_item.code_byte, code_item.last_of_run);
        mismatches++;
      end else begin
        want = code_q.pop_front();
        if (code_item.code_byte !== want.code_byte) begin
          $display("%0t: code_byte expected %h actual %h",
                   $time, want.code_byte, code_item.code_byte);
          mismatches++;
        end
        if (code_item.last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run expected %b actual %b",
                   $time, want.last_of_run, code_item.last_of_run);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((data_valid && !data_stall) || (code_valid && !code_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    s7e8_pkg::in_item_t it;
    int                 len;
    int                 next_drain;
    add_row(s7e8_pkg::CMD_END,  8'hA5, 1, s7e8_pkg::ZERO_CODE, 8'h00);
    add_row(s7e8_pkg::CMD_DATA, 8'h00, 0, 8'h00, 8'h00);
    add_row(s7e8_pkg::CMD_END,  8'h5A, 2, 8'h80, 8'h00);
    add_row(s7e8_pkg::CMD_DATA, 8'h05, 0, 8'h00, 8'h00);
    add_row(s7e8_pkg::CMD_END,  8'h00, 1, 8'h05, 8'h00);
    add_row(s7e8_pkg::CMD_DATA, 8'hFF, 0, 8'h00, 8'h00);
    add_row(s7e8_pkg::CMD_END,  8'hFF, 2, 8'hFF, 8'h40);
    add_row(s7e8_pkg::CMD_DATA, 8'h80, 0, 8'h00, 8'h00);
    add_row(s7e8_pkg::CMD_END,  8'h00, 2, 8'h80, 8'h40);
    add_row(s7e8_pkg::CMD_DATA, 8'h7F, 0, 8'h00, 8'h00);
    add_row(s7e8_pkg::CMD_END,  8'h00, 1, 8'h7F, 8'h00);
    // Eight bytes run the window through its wrap, then end at the start of a new window.
    for (int i = 0; i < 8; i++) add_row(s7e8_pkg::CMD_DATA, 8'hFF, PRED, 8'h00, 8'h00);
    add_row(s7e8_pkg::CMD_END,  8'h00, PRED, 8'h00, 8'h00);
    add_row(s7e8_pkg::CMD_DATA, 8'h01, PRED, 8'h00, 8'h00);
    add_row(s7e8_pkg::CMD_DATA, 8'h01, PRED, 8'h00, 8'h00);
    add_row(s7e8_pkg::CMD_END,  8'hFF, PRED, 8'h00, 8'h00);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].n, dir_rows[i].c0,
                                   dir_rows[i].c1);
    drain_all();

    next_drain = items_sent + DRAIN_STEP;
    while (items_sent < ITEMS) begin
      gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
      case ($urandom_range(0, 9))
        0: len = 0;
        1, 2, 3: len = $urandom_range(1, 7);
        4, 5, 6, 7: len = $urandom_range(8, 21);
        default: len = $urandom_range(22, 40);
      endcase
      for (int i = 0; i < len; i++) begin
        it.command   = s7e8_pkg::CMD_DATA;
        it.data_byte = pick_byte();
        calm = (items_sent >= ITEMS - CALM_ITEMS);
        send_req(it, PRED, 8'h00, 8'h00);
      end
      it.command   = s7e8_pkg::CMD_END;
      it.data_byte = 8'($urandom_range(0, 255));
      calm = (items_sent >= ITEMS - CALM_ITEMS);
      send_req(it, PRED, 8'h00, 8'h00);
      if (!calm && items_sent >= next_drain) begin
        drain_all();
        next_drain = items_sent + DRAIN_STEP;
      end
    end

    drain_all();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && code_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== seven_in_eight_byte_encoder_core.f =====
hw/rtl/s7e8_pkg.sv
hw/rtl/s7e8_in_reg.sv
hw/rtl/s7e8_pack.sv
hw/rtl/s7e8_out_buf.sv
hw/rtl/seven_in_eight_byte_encoder_core.sv
sim/tb_seven_in_eight_byte_encoder_core.sv
